/* hw/rtl/sgt_pkg.sv */
// Shared types and constants for the swipe gesture tracker.
// No dependencies; imported by every module of the block.
package sgt_pkg;

   localparam int COORD_WIDTH_DEF = 9;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_START_THRESHOLD  = 2'd0;
   localparam logic [1:0] REG_COMMIT_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_RELEASE_CONFIRM  = 2'd2;
   localparam logic [1:0] REG_SCREEN_WIDTH     = 2'd3;

   localparam logic [7:0] START_THRESHOLD_RST  = 8'd8;
   localparam logic [8:0] COMMIT_THRESHOLD_RST = 9'd80;
   localparam logic [3:0] RELEASE_CONFIRM_RST  = 4'd3;
   localparam logic [8:0] SCREEN_WIDTH_RST     = 9'd240;

   typedef enum logic [2:0] {
      ACT_NONE        = 3'd0,
      ACT_PRESS       = 3'd1,
      ACT_DRAG        = 3'd2,
      ACT_COMMIT_ANIM = 3'd3,
      ACT_CANCEL_ANIM = 3'd4,
      ACT_TAP         = 3'd5,
      ACT_ENTER_MENU  = 3'd6,
      ACT_CANCEL_DONE = 3'd7
   } action_type;

   typedef struct packed {
      logic [7:0] start_threshold;
      logic [8:0] commit_threshold;
      logic [3:0] release_confirm;
      logic [8:0] screen_width;
   } cfg_type;

endpackage

/* hw/rtl/swipe_gesture_tracker.sv */
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    cmd, pressed, point_x, page_active
// rsp       out        rsp_valid/rsp_ready    action, preview_x, preview_visible
// csr       in         APB write, pready=1    start/commit threshold, confirm, width
//
// One sample per clock unless the result register is full and rsp_ready is low.
// A transfer on req lands in the input register; once the result register is empty
// or taken, it is decided against the gesture state and loads the result register.
// Both registers advance together when an item waits and the result register is empty
// or taken; req_ready drops only while both registers hold items and rsp_ready is low.
// Reset is synchronous. Depends on sgt_pkg, sgt_csr and sgt_core.
module swipe_gesture_tracker
   import sgt_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic                      req_pressed,
   input  logic [COORD_WIDTH-1:0]    req_point_x,
   input  logic                      req_page_active,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_action,
   output logic [COORD_WIDTH-1:0]    rsp_preview_x,
   output logic                      rsp_preview_visible,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   cfg_type cfg;

   logic                   in_vld_ff;
   logic                   in_cmd_ff;
   logic                   in_pressed_ff;
   logic [COORD_WIDTH-1:0] in_point_x_ff;
   logic                   in_page_active_ff;

   logic                   rsp_vld_ff;
   action_type             rsp_action_ff;
   logic [COORD_WIDTH-1:0] rsp_preview_x_ff;
   logic                   rsp_visible_ff;

   action_type             core_action;
   logic [COORD_WIDTH-1:0] core_preview_x;
   logic                   core_visible;

   logic                   advance;
   logic                   req_xfer;

   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   sgt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sgt_core #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .step            (advance),
      .cmd             (in_cmd_ff),
      .pressed         (in_pressed_ff),
      .point_x         (in_point_x_ff),
      .page_active     (in_page_active_ff),
      .action          (core_action),
      .preview_x       (core_preview_x),
      .preview_visible (core_visible)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_cmd_ff         <= req_cmd;
         in_pressed_ff     <= req_pressed;
         in_point_x_ff     <= req_point_x;
         in_page_active_ff <= req_page_active;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_action_ff    <= core_action;
         rsp_preview_x_ff <= core_preview_x;
         rsp_visible_ff   <= core_visible;
      end
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_action          = rsp_action_ff;
   assign rsp_preview_x       = rsp_preview_x_ff;
   assign rsp_preview_visible = rsp_visible_ff;

`ifndef SYNTHESIS
   // a decided sample always shows up as a result on the next cycle
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("advance did not load the result register");

   // the preview layer is only shown while dragging or starting an animation
   a_visible_action: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_visible_ff) |-> (rsp_action_ff == ACT_DRAG ||
         rsp_action_ff == ACT_COMMIT_ANIM || rsp_action_ff == ACT_CANCEL_ANIM))
      else $error("preview visible with non-drag action");

   // an idle result carries a zero preview position
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_action_ff == ACT_NONE) |-> (rsp_preview_x_ff == '0 &&
         !rsp_visible_ff))
      else $error("none result with nonzero preview");
`endif

endmodule

/* hw/rtl/sgt_csr.sv */
// Configuration register file behind the APB-style port.
// Depends on sgt_pkg for register indexes, reset values and cfg_type.
module sgt_csr
   import sgt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   logic [7:0] start_threshold_ff;
   logic [8:0] commit_threshold_ff;
   logic [3:0] release_confirm_ff;
   logic [8:0] screen_width_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_threshold_ff  <= START_THRESHOLD_RST;
         commit_threshold_ff <= COMMIT_THRESHOLD_RST;
         release_confirm_ff  <= RELEASE_CONFIRM_RST;
         screen_width_ff     <= SCREEN_WIDTH_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_START_THRESHOLD:  start_threshold_ff  <= csr_pwdata[7:0];
            REG_COMMIT_THRESHOLD: commit_threshold_ff <= csr_pwdata[8:0];
            REG_RELEASE_CONFIRM:  release_confirm_ff  <= csr_pwdata[3:0];
            REG_SCREEN_WIDTH:     screen_width_ff     <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_START_THRESHOLD:  csr_prdata = {24'd0, start_threshold_ff};
         REG_COMMIT_THRESHOLD: csr_prdata = {23'd0, commit_threshold_ff};
         REG_RELEASE_CONFIRM:  csr_prdata = {28'd0, release_confirm_ff};
         REG_SCREEN_WIDTH:     csr_prdata = {23'd0, screen_width_ff};
         default:              csr_prdata = '0;
      endcase
   end

   assign cfg.start_threshold  = start_threshold_ff;
   assign cfg.commit_threshold = commit_threshold_ff;
   assign cfg.release_confirm  = release_confirm_ff;
   assign cfg.screen_width     = screen_width_ff;

endmodule

/* hw/rtl/sgt_core.sv */
// Gesture state and the per-sample decision logic.
// Depends on sgt_pkg for action_type and cfg_type.
module sgt_core
   import sgt_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   step,        // item moves into the result register
   input  logic                   cmd,
   input  logic                   pressed,
   input  logic [COORD_WIDTH-1:0] point_x,
   input  logic                   page_active,
   output action_type             action,
   output logic [COORD_WIDTH-1:0] preview_x,
   output logic                   preview_visible
);

   localparam int CMP_WIDTH = (COORD_WIDTH > 9) ? COORD_WIDTH : 9;

   logic [COORD_WIDTH-1:0] press_x_ff, press_x_in;
   logic [COORD_WIDTH-1:0] scaled_drag_ff, scaled_drag_in;
   logic [3:0]             confirm_cnt_ff, confirm_cnt_in;
   logic                   touch_down_ff, touch_down_in;
   logic                   drag_armed_ff, drag_armed_in;
   logic                   anim_running_ff, anim_running_in;
   logic                   anim_is_commit_ff, anim_is_commit_in;

   logic [COORD_WIDTH-1:0] sw;
   logic [COORD_WIDTH:0]   travel;
   logic                   travel_neg;
   logic [COORD_WIDTH-1:0] travel_mag;
   logic [COORD_WIDTH+1:0] triple;
   logic [COORD_WIDTH:0]   half;
   logic [COORD_WIDTH-1:0] drag_sat;
   logic                   arm_hit;
   logic                   commit_hit;

   assign sw         = COORD_WIDTH'(cfg.screen_width);
   assign travel     = {1'b0, press_x_ff} - {1'b0, point_x};
   assign travel_neg = travel[COORD_WIDTH];
   assign travel_mag = travel_neg ? '0 : travel[COORD_WIDTH-1:0];
   assign arm_hit    = !travel_neg && (travel_mag >= COORD_WIDTH'(cfg.start_threshold));
   // 3/2 scale: x*3 as shift-add, then drop the low bit
   assign triple     = {1'b0, travel_mag, 1'b0} + {2'b00, travel_mag};
   assign half       = triple[COORD_WIDTH+1:1];
   assign drag_sat   = (half > {1'b0, sw}) ? sw : half[COORD_WIDTH-1:0];
   assign commit_hit = CMP_WIDTH'(scaled_drag_ff) >= CMP_WIDTH'(cfg.commit_threshold);

   always_comb begin
      press_x_in        = press_x_ff;
      scaled_drag_in    = scaled_drag_ff;
      confirm_cnt_in    = confirm_cnt_ff;
      touch_down_in     = touch_down_ff;
      drag_armed_in     = drag_armed_ff;
      anim_running_in   = anim_running_ff;
      anim_is_commit_in = anim_is_commit_ff;
      action            = ACT_NONE;
      preview_x         = '0;
      preview_visible   = 1'b0;

      if (cmd) begin
         if (anim_running_ff) begin
            action            = anim_is_commit_ff ? ACT_ENTER_MENU : ACT_CANCEL_DONE;
            preview_x         = sw;
            scaled_drag_in    = '0;
            confirm_cnt_in    = '0;
            touch_down_in     = 1'b0;
            drag_armed_in     = 1'b0;
            anim_running_in   = 1'b0;
            anim_is_commit_in = 1'b0;
         end
      end else if (!page_active || anim_running_ff) begin
         // gated sample: no change
      end else if (pressed && !touch_down_ff) begin
         press_x_in     = point_x;
         scaled_drag_in = '0;
         drag_armed_in  = 1'b0;
         touch_down_in  = 1'b1;
         confirm_cnt_in = '0;
         action         = ACT_PRESS;
         preview_x      = sw;
      end else if (pressed) begin
         confirm_cnt_in = '0;
         if (arm_hit || drag_armed_ff) begin
            drag_armed_in   = 1'b1;
            scaled_drag_in  = drag_sat;
            action          = ACT_DRAG;
            preview_x       = sw - drag_sat;
            preview_visible = 1'b1;
         end
      end else if (touch_down_ff) begin
         if (confirm_cnt_ff < cfg.release_confirm) begin
            confirm_cnt_in = confirm_cnt_ff + 4'd1;
         end else begin
            touch_down_in  = 1'b0;
            confirm_cnt_in = '0;
            if (drag_armed_ff) begin
               anim_running_in   = 1'b1;
               anim_is_commit_in = commit_hit;
               preview_visible   = 1'b1;
               if (commit_hit) begin
                  action    = ACT_COMMIT_ANIM;
                  preview_x = '0;
               end else begin
                  action    = ACT_CANCEL_ANIM;
                  preview_x = sw;
               end
            end else begin
               action    = ACT_TAP;
               preview_x = sw;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_x_ff        <= '0;
         scaled_drag_ff    <= '0;
         confirm_cnt_ff    <= '0;
         touch_down_ff     <= 1'b0;
         drag_armed_ff     <= 1'b0;
         anim_running_ff   <= 1'b0;
         anim_is_commit_ff <= 1'b0;
      end else if (step) begin
         press_x_ff        <= press_x_in;
         scaled_drag_ff    <= scaled_drag_in;
         confirm_cnt_ff    <= confirm_cnt_in;
         touch_down_ff     <= touch_down_in;
         drag_armed_ff     <= drag_armed_in;
         anim_running_ff   <= anim_running_in;
         anim_is_commit_ff <= anim_is_commit_in;
      end
   end

endmodule
